// ===== rtl/rtc_pkg.sv =====
package rtc_pkg;

	// Default number of entries in each rotor table.
	localparam int ROTOR_LENGTH_DEF = 27;

	// Field widths of the command and result channels.
	localparam int CMD_W = 2;
	localparam int SEL_W = 2;
	localparam int POS_W = 5;
	localparam int SYM_W = 8;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ENCODE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_DECODE = 2'd2;
	localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

	// Rotor selection codes for a load.
	localparam logic [SEL_W-1:0] SEL_OUTER  = 2'd0;
	localparam logic [SEL_W-1:0] SEL_MIDDLE = 2'd1;
	localparam logic [SEL_W-1:0] SEL_INNER  = 2'd2;
	localparam logic [SEL_W-1:0] SEL_NONE   = 2'd3;

	// The one non-letter symbol that is substituted.
	localparam logic [SYM_W-1:0] HASH_SYM = 8'h23;

	// True for bytes that go through the rotors: letters and the hash sign.
	function automatic logic is_cipher_symbol(input logic [SYM_W-1:0] b);
		logic upper;
		logic lower;
		upper = (b >= 8'h41) && (b <= 8'h5A);
		lower = (b >= 8'h61) && (b <= 8'h7A);
		return upper || lower || (b == HASH_SYM);
	endfunction

endpackage

// ===== rtl/rtc_rotor_mem.sv =====
module rtc_rotor_mem #(
	parameter int DEPTH = rtc_pkg::ROTOR_LENGTH_DEF,
	parameter int IDX_W = $clog2(rtc_pkg::ROTOR_LENGTH_DEF)
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [IDX_W-1:0]         waddr,
	input  logic [rtc_pkg::SYM_W-1:0] wdata,
	input  logic [IDX_W-1:0]         raddr,
	output logic [rtc_pkg::SYM_W-1:0] rdata
);
	import rtc_pkg::*;

	logic [SYM_W-1:0] mem [DEPTH];

	// Single write port; the table has no reset and is defined once loaded.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/three_rotor_cipher_top.sv =====
// Three-rotor substitution cipher on byte symbols.
//
// Command channel: a transaction is taken at a rising clock edge where start
// is high and busy is low. cmd selects a rotor entry load, an encode or a
// decode; rotor_select, position and symbol carry the operands.
// A load writes one table entry and clears all rotor offsets; it returns
// no result. An encode or decode returns one result on
// out_symbol and not_found, shown for exactly one cycle while done is high.
// The receiver cannot stall, so a result is simply gone after that cycle.
//
// A byte that is not a letter or '#' is returned unchanged. A substituted
// byte runs up to two linear searches through a rotor table, one entry
// compared per cycle on a single comparator behind a registered memory read,
// each hit followed by a lookup in ST_LOOK and ST_LOOKW; a search with no
// match ends with not_found high. busy stays high throughout an encode or
// decode. The rotor offsets step as the result is delivered.
//
// Reset clears the sequencer and all three rotor offsets; the rotor tables
// keep no reset value and must be loaded before use.
module three_rotor_cipher_top #(
	parameter int ROTOR_LENGTH = rtc_pkg::ROTOR_LENGTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [rtc_pkg::CMD_W-1:0] cmd,
	input  logic [rtc_pkg::SEL_W-1:0] rotor_select,
	input  logic [rtc_pkg::POS_W-1:0] position,
	input  logic [rtc_pkg::SYM_W-1:0] symbol,
	output logic                      done,
	output logic [rtc_pkg::SYM_W-1:0] out_symbol,
	output logic                      not_found
);
	import rtc_pkg::*;

	localparam int IDX_W = $clog2(ROTOR_LENGTH);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ROTOR_LENGTH - 1);
	localparam logic [IDX_W-1:0] LEN_IDX  = IDX_W'(ROTOR_LENGTH);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SRCH  = 5'b00010,
		ST_LOOK  = 5'b00100,
		ST_LOOKW = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

	typedef enum logic [1:0] {
		TBL_OUTER,
		TBL_MIDDLE,
		TBL_INNER
	} tbl_t;

	state_t            state_q;
	state_t            state_next;
	logic              dec_q;
	logic              phase2_q;
	logic [SYM_W-1:0]  key_q;
	logic [IDX_W-1:0]  p_q;
	logic [IDX_W-1:0]  pos_q;
	logic [IDX_W-1:0]  p_s1;
	logic              v_s1;
	logic [SYM_W-1:0]  res_q;
	logic              miss_q;
	logic [IDX_W-1:0]  outer_off_q;
	logic [IDX_W-1:0]  middle_off_q;
	logic [IDX_W-1:0]  inner_off_q;

	logic              accept;
	logic              load_ok;
	logic [IDX_W-1:0]  load_idx;
	logic              we_outer;
	logic              we_middle;
	logic              we_inner;
	tbl_t              tbl;
	logic [IDX_W-1:0]  rd_pos;
	logic [IDX_W-1:0]  rd_off;
	logic [IDX_W-1:0]  raddr;
	logic [SYM_W-1:0]  rd_outer;
	logic [SYM_W-1:0]  rd_middle;
	logic [SYM_W-1:0]  rd_inner;
	logic [SYM_W-1:0]  rd_data;
	logic              hit;
	logic              exhausted;

	assign accept   = start && (state_q == ST_IDLE);
	assign busy     = (state_q != ST_IDLE);
	assign done     = (state_q == ST_OUT);
	assign out_symbol = res_q;
	assign not_found  = miss_q;

	// A load lands only on an existing rotor and an entry inside the table.
	assign load_ok   = accept && (cmd == CMD_LOAD) && (rotor_select != SEL_NONE) &&
		(int'(position) < ROTOR_LENGTH);
	assign load_idx  = IDX_W'(position);
	assign we_outer  = load_ok && (rotor_select == SEL_OUTER);
	assign we_middle = load_ok && (rotor_select == SEL_MIDDLE);
	assign we_inner  = load_ok && (rotor_select == SEL_INNER);

	// Table in use: searches go inner then middle for encode, outer twice for
	// decode; lookups go outer twice for encode, middle then inner for decode.
	always_comb begin
		if (state_q == ST_SRCH) begin
			if (dec_q) begin
				tbl = TBL_OUTER;
			end else begin
				tbl = phase2_q ? TBL_MIDDLE : TBL_INNER;
			end
		end else begin
			if (dec_q) begin
				tbl = phase2_q ? TBL_INNER : TBL_MIDDLE;
			end else begin
				tbl = TBL_OUTER;
			end
		end
	end

	// Offset of the selected rotor and the data returned from it.
	always_comb begin
		unique case (tbl)
			TBL_OUTER: begin
				rd_off  = outer_off_q;
				rd_data = rd_outer;
			end
			TBL_MIDDLE: begin
				rd_off  = middle_off_q;
				rd_data = rd_middle;
			end
			TBL_INNER: begin
				rd_off  = inner_off_q;
				rd_data = rd_inner;
			end
			default: begin
				rd_off  = outer_off_q;
				rd_data = rd_outer;
			end
		endcase
	end

	// Rotor position to table entry: (pos - offset) mod ROTOR_LENGTH.
	assign rd_pos = (state_q == ST_LOOK) ? pos_q : p_q;
	assign raddr  = (rd_pos - rd_off) + ((rd_pos < rd_off) ? LEN_IDX : '0);

	rtc_rotor_mem #(.DEPTH(ROTOR_LENGTH), .IDX_W(IDX_W)) u_outer (
		.clk   (clk),
		.we    (we_outer),
		.waddr (load_idx),
		.wdata (symbol),
		.raddr (raddr),
		.rdata (rd_outer)
	);

	rtc_rotor_mem #(.DEPTH(ROTOR_LENGTH), .IDX_W(IDX_W)) u_middle (
		.clk   (clk),
		.we    (we_middle),
		.waddr (load_idx),
		.wdata (symbol),
		.raddr (raddr),
		.rdata (rd_middle)
	);

	rtc_rotor_mem #(.DEPTH(ROTOR_LENGTH), .IDX_W(IDX_W)) u_inner (
		.clk   (clk),
		.we    (we_inner),
		.waddr (load_idx),
		.wdata (symbol),
		.raddr (raddr),
		.rdata (rd_inner)
	);

	// The shared comparator checks the entry read in the previous cycle.
	assign hit       = v_s1 && (rd_data == key_q);
	assign exhausted = v_s1 && (p_s1 == LAST_IDX);

	// Sequencer next state.
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && ((cmd == CMD_ENCODE) || (cmd == CMD_DECODE))) begin
					state_next = is_cipher_symbol(symbol) ? ST_SRCH : ST_OUT;
				end
			end
			ST_SRCH: begin
				if (hit) begin
					state_next = ST_LOOK;
				end else if (exhausted) begin
					state_next = ST_OUT;
				end
			end
			ST_LOOK: begin
				state_next = ST_LOOKW;
			end
			ST_LOOKW: begin
				state_next = phase2_q ? ST_OUT : ST_SRCH;
			end
			ST_OUT: begin
				state_next = ST_IDLE;
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	// Control state and rotor offsets.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			v_s1         <= 1'b0;
			outer_off_q  <= '0;
			middle_off_q <= '0;
			inner_off_q  <= '0;
		end else begin
			state_q <= state_next;
			v_s1    <= (state_q == ST_SRCH) && (state_next == ST_SRCH);
			if (load_ok) begin
				outer_off_q  <= '0;
				middle_off_q <= '0;
				inner_off_q  <= '0;
			end else if (state_q == ST_OUT) begin
				// Odometer step: each wrap carries into the next rotor.
				if (inner_off_q == LAST_IDX) begin
					inner_off_q <= '0;
					if (middle_off_q == LAST_IDX) begin
						middle_off_q <= '0;
						outer_off_q  <= (outer_off_q == LAST_IDX) ? '0 : outer_off_q + 1'b1;
					end else begin
						middle_off_q <= middle_off_q + 1'b1;
					end
				end else begin
					inner_off_q <= inner_off_q + 1'b1;
				end
			end
		end
	end

	// Transaction payload, search counters and result.
	always_ff @(posedge clk) begin
		p_s1 <= p_q;
		unique case (state_q)
			ST_IDLE: begin
				dec_q    <= (cmd == CMD_DECODE);
				phase2_q <= 1'b0;
				key_q    <= symbol;
				p_q      <= '0;
				res_q    <= symbol;
				miss_q   <= 1'b0;
			end
			ST_SRCH: begin
				if (hit) begin
					pos_q <= p_s1;
				end else if (exhausted) begin
					res_q  <= '0;
					miss_q <= 1'b1;
				end
				if (p_q != LAST_IDX) begin
					p_q <= p_q + 1'b1;
				end
			end
			ST_LOOK: begin
			end
			ST_LOOKW: begin
				if (phase2_q) begin
					res_q <= rd_data;
				end else begin
					key_q    <= rd_data;
					phase2_q <= 1'b1;
					p_q      <= '0;
				end
			end
			ST_OUT: begin
			end
			default: begin
			end
		endcase
	end

endmodule
